// File: src/n_run_gap_segmenter_macros.svh
// ----------------------------------------------------------------------------
// n_run_gap_segmenter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef N_RUN_GAP_SEGMENTER_MACROS_SVH
`define N_RUN_GAP_SEGMENTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRGS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NRGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/nrgs_pkg.sv
// ----------------------------------------------------------------------------
// nrgs_pkg
// Types, constants and helper functions shared by the gap segmenter modules.
// ----------------------------------------------------------------------------
package nrgs_pkg;

    localparam int POS_BITS = 32;
    localparam int CNT_BITS = 32;
    localparam int CMP_BITS = (POS_BITS > 32) ? POS_BITS : 32;
    localparam int OUT_BITS = 32;

    localparam logic [7:0] GAP_CHAR = 8'h6E;

    localparam logic KIND_CONTIG = 1'b0;
    localparam logic KIND_GAP    = 1'b1;

    localparam logic CFG_MIN_CONTIG   = 1'b0;
    localparam logic CFG_MIN_SCAFFOLD = 1'b1;

    localparam logic [31:0] MIN_CONTIG_RESET   = 32'd25;
    localparam logic [31:0] MIN_SCAFFOLD_RESET = 32'd50000;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [CNT_BITS-1:0] t_cnt;

    localparam t_pos POS_MAX = '1;
    localparam t_cnt CNT_MAX = '1;

    // One record as the front end plans it; positions are 0-based, end exclusive.
    typedef struct packed {
        logic kind;
        t_pos beg;
        t_pos fin;
        t_cnt part;
        t_cnt contig;
    } t_rec;

    // Slot 0: contig closed by a gap, slot 1: the gap, slot 2: closing contig.
    typedef struct packed {
        logic [2:0]     mask;
        t_rec [2:0]     rec;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic                kind;
        logic [OUT_BITS-1:0] start_pos;
        logic [OUT_BITS-1:0] end_pos;
        logic [OUT_BITS-1:0] part_number;
        logic [OUT_BITS-1:0] contig_number;
        logic [OUT_BITS-1:0] part_length;
        logic                scaffold;
        logic                last;
    } t_out;

    function automatic t_pos sat_pos_inc(input t_pos v);
        return (v == POS_MAX) ? POS_MAX : v + t_pos'(1);
    endfunction

    function automatic t_cnt sat_cnt_add(input t_cnt v, input logic [1:0] k);
        logic [CNT_BITS:0] s;
        s = {1'b0, v} + (CNT_BITS+1)'(k);
        return s[CNT_BITS] ? CNT_MAX : s[CNT_BITS-1:0];
    endfunction

endpackage

// File: src/nrgs_front.sv
// ----------------------------------------------------------------------------
// nrgs_front
// Accepts bases, tracks runs of n and plans the records each base causes.
// ----------------------------------------------------------------------------
module nrgs_front import nrgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    output logic        o_ready,
    input  logic [31:0] i_min_contig,
    input  logic        i_full,
    output logic        o_push,
    output t_desc       o_desc
);

    t_pos r_pos, r_contig_begin, r_run_begin;
    logic r_in_gap;
    t_cnt r_part, r_contig;

    t_pos n_pos, n_contig_begin, n_run_begin;
    logic n_in_gap;
    t_cnt n_part, n_contig;

    logic       acc, is_n, close_gap, v_a, v_g, v_b;
    t_pos       here, after, rb, cb_new, gap_end;
    logic [1:0] k_a, k_g, k_b;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;

    always_comb begin
        here     = r_pos;
        after    = sat_pos_inc(here);
        is_n     = (i_char == GAP_CHAR);
        rb       = (is_n && !r_in_gap) ? here : r_run_begin;
        // Run length here - rb never goes negative: positions only grow.
        close_gap = !is_n && r_in_gap &&
                    (CMP_BITS'(here - r_run_begin) >= CMP_BITS'(i_min_contig));
        v_g      = (is_n && i_last) || close_gap;
        v_a      = v_g && (rb != r_contig_begin);
        v_b      = !is_n && i_last;
        gap_end  = is_n ? after : here;
        cb_new   = close_gap ? here : r_contig_begin;

        k_a = {1'b0, v_a};
        k_g = {1'b0, v_g};
        k_b = {1'b0, v_b};

        o_desc.mask = {v_b, v_g, v_a};

        o_desc.rec[0].kind   = KIND_CONTIG;
        o_desc.rec[0].beg    = r_contig_begin;
        o_desc.rec[0].fin    = rb;
        o_desc.rec[0].part   = sat_cnt_add(r_part, 2'd1);
        o_desc.rec[0].contig = sat_cnt_add(r_contig, 2'd1);

        o_desc.rec[1].kind   = KIND_GAP;
        o_desc.rec[1].beg    = rb;
        o_desc.rec[1].fin    = gap_end;
        o_desc.rec[1].part   = sat_cnt_add(r_part, k_a + 2'd1);
        o_desc.rec[1].contig = '0;

        o_desc.rec[2].kind   = KIND_CONTIG;
        o_desc.rec[2].beg    = cb_new;
        o_desc.rec[2].fin    = after;
        o_desc.rec[2].part   = sat_cnt_add(r_part, k_a + k_g + 2'd1);
        o_desc.rec[2].contig = sat_cnt_add(r_contig, k_a + 2'd1);

        o_push = acc && (v_a || v_g || v_b);

        if (i_last) begin
            n_pos          = '0;
            n_contig_begin = '0;
            n_run_begin    = '0;
            n_in_gap       = 1'b0;
            n_part         = '0;
            n_contig       = '0;
        end else begin
            n_pos          = after;
            n_contig_begin = cb_new;
            n_run_begin    = rb;
            n_in_gap       = is_n;
            n_part         = sat_cnt_add(r_part, k_a + k_g + k_b);
            n_contig       = sat_cnt_add(r_contig, k_a + k_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_contig_begin <= '0;
            r_run_begin    <= '0;
            r_in_gap       <= 1'b0;
            r_part         <= '0;
            r_contig       <= '0;
        end else if (acc) begin
            r_pos          <= n_pos;
            r_contig_begin <= n_contig_begin;
            r_run_begin    <= n_run_begin;
            r_in_gap       <= n_in_gap;
            r_part         <= n_part;
            r_contig       <= n_contig;
        end
    end

endmodule

// File: src/nrgs_queue.sv
// ----------------------------------------------------------------------------
// nrgs_queue
// Two-entry queue of planned record groups between front and back end.
// ----------------------------------------------------------------------------
module nrgs_queue import nrgs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_desc  i_desc,
    input  logic   i_pop,
    output t_desc  o_head,
    output t_qstat o_stat
);

    t_desc      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: src/nrgs_back.sv
// ----------------------------------------------------------------------------
// nrgs_back
// Issues planned records into the output register, one per cycle when ready.
// ----------------------------------------------------------------------------
module nrgs_back import nrgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_desc       i_head,
    input  t_qstat      i_stat,
    output logic        o_pop,
    input  logic [31:0] i_min_scaffold,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_rec
);

    logic [2:0] r_done;
    logic       r_valid;
    t_out       r_rec;

    logic [2:0] pending, pick, rest;
    logic [1:0] sel;
    logic       load, last;
    t_rec       cur;
    t_pos       len;
    t_out       n_rec;

    always_comb begin
        pending = i_stat.empty ? 3'b000 : (i_head.mask & ~r_done);
        if (pending[0]) begin
            sel  = 2'd0;
            pick = 3'b001;
        end else if (pending[1]) begin
            sel  = 2'd1;
            pick = 3'b010;
        end else begin
            sel  = 2'd2;
            pick = 3'b100;
        end
        rest = pending & ~pick;
        last = (rest == 3'b000);
        load = (pending != 3'b000) && (!r_valid || i_ready);
        o_pop = load && last;

        cur = i_head.rec[sel];
        len = (cur.fin >= cur.beg) ? (cur.fin - cur.beg) : '0;
        n_rec.kind          = cur.kind;
        n_rec.start_pos     = OUT_BITS'(sat_pos_inc(cur.beg));
        n_rec.end_pos       = OUT_BITS'(cur.fin);
        n_rec.part_number   = OUT_BITS'(cur.part);
        n_rec.contig_number = OUT_BITS'(cur.contig);
        n_rec.part_length   = OUT_BITS'(len);
        n_rec.scaffold      = (cur.kind == KIND_GAP) &&
                              (CMP_BITS'(len) >= CMP_BITS'(i_min_scaffold));
        n_rec.last          = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 3'b000;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_done  <= last ? 3'b000 : (r_done | pick);
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

// File: src/n_run_gap_segmenter.sv
// ----------------------------------------------------------------------------
// n_run_gap_segmenter
// Splits a stream of sequence bases into contig and gap records.
// ----------------------------------------------------------------------------
// One base is accepted per clock cycle while the queue is not full. A base
// that causes at most one record leaves the rate at one transaction per cycle
// while the output is ready; a base that causes two or three records (a gap
// closing, or a gap at the end of a sequence) has them issued one after
// another, since the single output register issues one record per cycle. A
// two-entry queue between the front end (run tracking and record planning)
// and the back end (record issue) absorbs such bursts; a record passes a queue
// entry and then the output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module n_run_gap_segmenter import nrgs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] base_char
    input  logic         s_axis_tlast,   // last_base
    // Record stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // start_pos, end_pos, part_number,
                                         // contig_number, part_length
    output logic [1:0]   m_axis_tuser,   // [0] record_kind, [1] scaffold_gap
    output logic         m_axis_tlast,   // last_of_run
    // Configuration writes
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

`include "n_run_gap_segmenter_macros.svh"

    // Config regs; the user writes only while the block is idle (unenforced).
    logic [31:0] r_min_contig;
    logic [31:0] r_min_scaffold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_contig   <= MIN_CONTIG_RESET;
            r_min_scaffold <= MIN_SCAFFOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_CONTIG:   r_min_contig   <= i_cfg_data;
                CFG_MIN_SCAFFOLD: r_min_scaffold <= i_cfg_data;
                default:          r_min_contig   <= r_min_contig;
            endcase
        end
    end

    logic   push, pop;
    t_desc  desc, head;
    t_qstat qstat;
    t_out   rec;

    // The front end plans every record a base causes in one step.
    nrgs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_char       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_ready      (s_axis_tready),
        .i_min_contig (r_min_contig),
        .i_full       (qstat.full),
        .o_push       (push),
        .o_desc       (desc)
    );

    nrgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // The back end walks a planned group and finishes each record's fields.
    nrgs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_stat         (qstat),
        .o_pop          (pop),
        .i_min_scaffold (r_min_scaffold),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_rec          (rec)
    );

    assign m_axis_tdata = {rec.part_length, rec.contig_number, rec.part_number,
                           rec.end_pos, rec.start_pos};
    assign m_axis_tuser = {rec.scaffold, rec.kind};
    assign m_axis_tlast = rec.last;

    // Gap records never carry a contig number.
    `NRGS_ASSERT_SAME(a_gap_no_contig, m_axis_tvalid && rec.kind == KIND_GAP,
        rec.contig_number == '0, "gap record with nonzero contig number")
    // Only gap records can be flagged as scaffold-level.
    `NRGS_ASSERT_SAME(a_scaffold_is_gap, m_axis_tvalid && rec.scaffold,
        rec.kind == KIND_GAP, "contig record flagged as scaffold gap")
    // The queue is never popped while empty nor pushed while full.
    `NRGS_ASSERT_SAME(a_queue_bounds, push || pop,
        !(push && qstat.full) && !(pop && qstat.empty), "queue over or underflow")
    // A stalled input side means records are waiting in the queue.
    `NRGS_ASSERT_NEXT(a_stall_has_work, !s_axis_tready,
        !qstat.empty || push, "input stalled with an empty queue")

endmodule
